// ----- rtl/core/two_tone_sine_synthesizer_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Two-tone sine synthesizer: assertion macros
// Concurrent assertion wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef TWO_TONE_SINE_SYNTHESIZER_UNIT_DEFINES_SVH
`define TWO_TONE_SINE_SYNTHESIZER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define TTS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked at every edge
`define TTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TTS_ASSERT(lbl, clk, rstn, prop, msg)
`define TTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- rtl/core/tts_pkg.sv -----
// ----------------------------------------------------------------------------
// Two-tone sine synthesizer package
// Register map, reset values and the quarter-wave sine table generator.
// ----------------------------------------------------------------------------
package tts_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_A_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_A_AMP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_B_AMP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 3'd5;

  localparam logic [31:0]        RST_A_STEP = 32'd12884902;
  localparam logic [31:0]        RST_B_STEP = 32'd25769803;
  localparam logic signed [15:0] RST_A_AMP  = 16'sd512;
  localparam logic signed [15:0] RST_B_AMP  = 16'sd1024;
  localparam logic [15:0]        RST_GAIN   = 16'd5120;
  localparam logic [7:0]         RST_OFFSET = 8'd128;

  localparam int DAC_W   = 8;
  localparam int SINE_W  = 15;
  localparam int FRAC_SH = 31;

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint Q30_ONE     = 64'sd1073741824;

  // Taylor series of sin(x), x in Q30, rounded to Q15 magnitude
  function automatic logic [SINE_W-1:0] tts_sine_q15(input longint x);
    longint x2;
    longint term;
    longint sum;
    longint r;
    x2   = (x * x) / Q30_ONE;
    term = x;
    sum  = x;
    term = -((term * x2) / Q30_ONE) / 6;   sum = sum + term;
    term = -((term * x2) / Q30_ONE) / 20;  sum = sum + term;
    term = -((term * x2) / Q30_ONE) / 42;  sum = sum + term;
    term = -((term * x2) / Q30_ONE) / 72;  sum = sum + term;
    term = -((term * x2) / Q30_ONE) / 110; sum = sum + term;
    term = -((term * x2) / Q30_ONE) / 156; sum = sum + term;
    term = -((term * x2) / Q30_ONE) / 210; sum = sum + term;
    if (sum < 0) sum = 0;
    r = (sum + 64'sd16384) >>> 15;
    if (r > 64'sd32767) r = 64'sd32767;
    return r[SINE_W-1:0];
  endfunction

endpackage

// ----- rtl/core/tts_if.sv -----
// ----------------------------------------------------------------------------
// Two-tone sine synthesizer channels
// Valid/ready interfaces for the tick, sample and register write channels.
// ----------------------------------------------------------------------------
interface tts_in_if;
  logic valid;
  logic ready;
  logic tick;
  modport source(output valid, output tick, input ready);
  modport sink(input valid, input tick, output ready);
endinterface

interface tts_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  dac_code;
  logic        clipped;
  logic [31:0] sample_number;
  modport source(output valid, output dac_code, output clipped, output sample_number,
                 input ready);
  modport sink(input valid, input dac_code, input clipped, input sample_number,
               output ready);
endinterface

interface tts_cfg_if import tts_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface

// ----- rtl/core/tts_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/tts_sine_rom.sv -----
// ----------------------------------------------------------------------------
// Quarter-wave sine ROM
// QUARTER_LEN+1 Q15 magnitudes from 0 to pi/2, registered read.
// ----------------------------------------------------------------------------
module tts_sine_rom import tts_pkg::*; #(
  parameter int QUARTER_LEN = 256
) (
  input  logic                               clk,
  input  logic [$clog2(QUARTER_LEN+1)-1:0]   addr,
  output logic [SINE_W-1:0]                  data_r
);

  logic [SINE_W-1:0] tab [QUARTER_LEN+1];

  for (genvar k = 0; k <= QUARTER_LEN; k++) begin : g_tab
    localparam longint X = (longint'(k) * HALF_PI_Q30 + longint'(QUARTER_LEN / 2))
                           / longint'(QUARTER_LEN);
    assign tab[k] = tts_sine_q15(X);
  end

  always_ff @(posedge clk) begin
    data_r <= tab[addr];
  end

endmodule

// ----- rtl/core/two_tone_sine_synthesizer_unit.sv -----
// ----------------------------------------------------------------------------
// Two-tone sine synthesizer
// Per tick, sums NUM_TONES table sines, applies gain and offset, saturates.
// ----------------------------------------------------------------------------
// Usage:
//   in_if   : one transfer per sample tick; tick = 0 is taken and ignored.
//   out_if  : one transfer per tick = 1 with dac_code, clipped flag and the
//             count of samples produced before this one.
//   cfg_if  : register writes, index 0..5 as in the register map; always ready,
//             other indexes are dropped. Write only while the block is idle.
// Timing:
//   A tick occupies the engine until its sample reaches the output register:
//   the phase RAM is read, updated and written back one tone per cycle, then
//   the sine ROM, amplitude multiply, accumulate, gain multiply and output
//   stages follow. A new tick is taken once the engine is back to idle; the
//   output register holds a finished sample meanwhile.
// Reset:
//   Phases and the sample count read as zero; registers take their defaults.
// Stall:
//   A sample waiting in the output register holds; the engine finishes the
//   next sample and waits in its last stage until the register frees up.
// ----------------------------------------------------------------------------
`include "two_tone_sine_synthesizer_unit_defines.svh"

module two_tone_sine_synthesizer_unit import tts_pkg::*; #(
  parameter int NUM_TONES        = 2,
  parameter int SINE_TABLE_DEPTH = 1024,
  parameter int PHASE_BITS       = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  tts_in_if.sink        in_if,
  tts_out_if.source     out_if,
  tts_cfg_if.sink       cfg_if
);

  localparam int TONE_W = (NUM_TONES > 1) ? $clog2(NUM_TONES) : 1;
  localparam int CNT_W  = $clog2(NUM_TONES + 1);
  localparam int LG     = $clog2(SINE_TABLE_DEPTH);
  localparam int QL     = SINE_TABLE_DEPTH / 4;
  localparam int ROM_AW = $clog2(QL + 1);
  localparam int SUM_W  = 32 + CNT_W;
  localparam int V_W    = SUM_W + 17;
  localparam int FL_W   = V_W - FRAC_SH;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_MIX  = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  // configuration
  logic [31:0]        a_step_r, b_step_r;
  logic signed [15:0] a_amp_r, b_amp_r;
  logic [15:0]        gain_r;
  logic [7:0]         offset_r;
  logic               cfg_acc;

  assign cfg_if.ready = 1'b1;
  assign cfg_acc      = cfg_if.valid && cfg_if.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_step_r <= RST_A_STEP;
      b_step_r <= RST_B_STEP;
      a_amp_r  <= RST_A_AMP;
      b_amp_r  <= RST_B_AMP;
      gain_r   <= RST_GAIN;
      offset_r <= RST_OFFSET;
    end else if (cfg_acc) begin
      unique case (cfg_if.index)
        CFG_A_STEP: a_step_r <= cfg_if.data;
        CFG_B_STEP: b_step_r <= cfg_if.data;
        CFG_A_AMP:  a_amp_r  <= cfg_if.data[15:0];
        CFG_B_AMP:  b_amp_r  <= cfg_if.data[15:0];
        CFG_GAIN:   gain_r   <= cfg_if.data[15:0];
        CFG_OFFSET: offset_r <= cfg_if.data[7:0];
        default: ;
      endcase
    end
  end

  // control
  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  iss_cnt_r, iss_cnt_nxt;
  logic              in_acc, issue;
  logic [TONE_W-1:0] iss_tone;
  logic              out_load;

  logic              s1_vld_r, s1_last_r;
  logic [TONE_W-1:0] s1_tone_r;
  logic              s2_vld_r, s2_last_r, s2_neg_r;
  logic [TONE_W-1:0] s2_tone_r;
  logic              s3_vld_r, s3_last_r;
  logic signed [31:0] p_r, p_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;
  logic signed [V_W-1:0]   v_r;

  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign issue       = (state_r == ST_RUN) && (iss_cnt_r < CNT_W'(NUM_TONES));
  assign iss_tone    = iss_cnt_r[TONE_W-1:0];

  always_comb begin
    state_nxt   = state_r;
    iss_cnt_nxt = iss_cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_if.tick) begin
          state_nxt   = ST_RUN;
          iss_cnt_nxt = '0;
        end
      end
      ST_RUN: begin
        if (issue) iss_cnt_nxt = iss_cnt_r + CNT_W'(1);
        if (s3_vld_r && s3_last_r) state_nxt = ST_MIX;
      end
      ST_MIX: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      iss_cnt_r <= '0;
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      iss_cnt_r <= iss_cnt_nxt;
      s1_vld_r  <= issue;
      s2_vld_r  <= s1_vld_r;
      s3_vld_r  <= s2_vld_r;
    end
  end

  // phase RAM read-modify-write
  logic [PHASE_BITS-1:0] ram_rdata, phase_cur, phase_nxt;
  logic [NUM_TONES-1:0]  phase_vld_r;
  logic [31:0]           step_sel;
  logic [LG-1:0]         tab_a;
  logic [ROM_AW-1:0]     idx_ext, rom_addr;
  logic [SINE_W-1:0]     rom_data;

  tts_ram #(
    .WIDTH (PHASE_BITS),
    .DEPTH (NUM_TONES)
  ) u_phase_ram (
    .clk   (clk),
    .we    (s1_vld_r),
    .waddr (s1_tone_r),
    .wdata (phase_nxt),
    .re    (issue),
    .raddr (iss_tone),
    .rdata (ram_rdata)
  );

  always_comb begin
    if (s1_tone_r == TONE_W'(0)) begin
      step_sel = a_step_r;
    end else if (NUM_TONES > 1 && s1_tone_r == TONE_W'(1)) begin
      step_sel = b_step_r;
    end else begin
      step_sel = '0;
    end
  end

  assign phase_cur = phase_vld_r[s1_tone_r] ? ram_rdata : '0;
  assign phase_nxt = phase_cur + PHASE_BITS'(step_sel);
  assign tab_a     = phase_cur[PHASE_BITS-1 -: LG];
  assign idx_ext   = {1'b0, tab_a[LG-3:0]};
  assign rom_addr  = tab_a[LG-2] ? (ROM_AW'(QL) - idx_ext) : idx_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_vld_r <= '0;
    end else if (s1_vld_r) begin
      phase_vld_r[s1_tone_r] <= 1'b1;
    end
  end

  tts_sine_rom #(
    .QUARTER_LEN (QL)
  ) u_sine_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (rom_data)
  );

  // amplitude multiply and accumulate
  logic signed [15:0] amp_sel, sine_val;

  always_comb begin
    if (s2_tone_r == TONE_W'(0)) begin
      amp_sel = a_amp_r;
    end else if (NUM_TONES > 1 && s2_tone_r == TONE_W'(1)) begin
      amp_sel = b_amp_r;
    end else begin
      amp_sel = '0;
    end
  end

  assign sine_val = s2_neg_r ? -$signed({1'b0, rom_data}) : $signed({1'b0, rom_data});
  assign p_nxt    = amp_sel * sine_val;

  always_comb begin
    acc_nxt = acc_r;
    if (in_acc) begin
      acc_nxt = '0;
    end else if (s3_vld_r) begin
      acc_nxt = acc_r + SUM_W'(p_r);
    end
  end

  always_ff @(posedge clk) begin
    s1_tone_r <= iss_tone;
    s1_last_r <= (iss_cnt_r == CNT_W'(NUM_TONES - 1));
    s2_tone_r <= s1_tone_r;
    s2_last_r <= s1_last_r;
    s2_neg_r  <= tab_a[LG-1];
    s3_last_r <= s2_last_r;
    p_r       <= p_nxt;
    acc_r     <= acc_nxt;
    if (state_r == ST_MIX) begin
      v_r <= acc_r * $signed({1'b0, gain_r});
    end
  end

  // floor, offset, saturate
  logic signed [FL_W:0] code_sum;
  logic                 code_neg, code_over;
  logic [DAC_W-1:0]     code_sat;

  logic               out_vld_r;
  logic [DAC_W-1:0]   out_code_r;
  logic               out_clip_r;
  logic [31:0]        out_num_r;
  logic [31:0]        smp_cnt_r;

  assign code_sum  = $signed({v_r[V_W-1], v_r[V_W-1:FRAC_SH]})
                   + $signed({{(FL_W - DAC_W + 1){1'b0}}, offset_r});
  assign code_neg  = code_sum[FL_W];
  assign code_over = !code_neg && (code_sum[FL_W-1:DAC_W] != '0);
  assign code_sat  = code_neg ? '0 : (code_over ? '1 : code_sum[DAC_W-1:0]);
  assign out_load  = (state_r == ST_OUT) && (!out_vld_r || out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
      smp_cnt_r <= '0;
    end else begin
      if (out_load) begin
        out_vld_r <= 1'b1;
        smp_cnt_r <= smp_cnt_r + 32'd1;
      end else if (out_if.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_code_r <= code_sat;
      out_clip_r <= code_neg || code_over;
      out_num_r  <= smp_cnt_r;
    end
  end

  assign out_if.valid         = out_vld_r;
  assign out_if.dac_code      = out_code_r;
  assign out_if.clipped       = out_clip_r;
  assign out_if.sample_number = out_num_r;

  // checks
  `TTS_ASSERT(a_tick_starts_run, clk, rst_n, (in_acc && in_if.tick) |=> (state_r == ST_RUN), "tick did not start the engine")
  `TTS_ASSERT(a_cnt_per_sample, clk, rst_n, out_load |=> (smp_cnt_r == $past(smp_cnt_r) + 32'd1), "sample count out of step")
  `TTS_ASSERT(a_idle_drained, clk, rst_n, (state_r == ST_IDLE) |-> (!s1_vld_r && !s2_vld_r && !s3_vld_r), "pipeline busy while idle")
  `TTS_ASSERT_ALWAYS(a_wb_in_range, clk, (rst_n && s1_vld_r) |-> (s1_tone_r <= TONE_W'(NUM_TONES - 1)), "phase write beyond last tone")

endmodule
